/* src/cc20_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_pkg
// Types, constants and round functions shared by the ChaCha20 cipher block.
// ----------------------------------------------------------------------------
package cc20_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_PART0       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_PART1       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_PART2       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_PART3       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_NONCE_LOW       = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_NONCE_HIGH      = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_COUNTER = 3'd6;

	// The "expand 32-byte k" constant words.
	localparam logic [31:0] SIGMA0 = 32'h6170_7865;
	localparam logic [31:0] SIGMA1 = 32'h3320_646e;
	localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
	localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

	typedef struct packed {
		logic [7:0] plaintext_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] cipher_byte;
		logic       last_out;
	} out_word_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;       // copy the start words into the round registers
		logic round;      // apply one half round
		logic diagonal;   // half round works on diagonals instead of columns
		logic feed;       // feed-forward into the keystream registers
		logic emit_in;    // produce a result from the word at the input
		logic emit_held;  // produce a result from the captured word
	} cc20_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic pos_zero;   // next byte starts a new keystream block
		logic out_busy;   // output register full and stalled
	} cc20_sts_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} quad_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic quad_t quarter_round(input quad_t x);
		quad_t y;
		y = x;
		y.a = y.a + y.b; y.d = rotl(y.d ^ y.a, 16);
		y.c = y.c + y.d; y.b = rotl(y.b ^ y.c, 12);
		y.a = y.a + y.b; y.d = rotl(y.d ^ y.a, 8);
		y.c = y.c + y.d; y.b = rotl(y.b ^ y.c, 7);
		return y;
	endfunction

endpackage

/* src/cc20_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_ctrl
// Sequencer: accepts input words, runs the round iterations for a new block.
// ----------------------------------------------------------------------------
module cc20_ctrl import cc20_pkg::*; #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  cc20_sts_t sts,
	output cc20_cmd_t cmd
);

	localparam int HALF_ROUNDS = 2 * DOUBLE_ROUNDS;
	localparam int STEP_W      = $clog2(HALF_ROUNDS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(HALF_ROUNDS - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_FEED  = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]        state_q;
	logic [1:0]        state_d;
	logic [STEP_W-1:0] round_step_q;
	logic              accept;

	assign in_stall = (state_q != ST_IDLE) || sts.out_busy;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd           = '0;
		cmd.load      = accept && sts.pos_zero;
		cmd.emit_in   = accept && !sts.pos_zero;
		cmd.round     = (state_q == ST_ROUND);
		cmd.diagonal  = round_step_q[0];
		cmd.feed      = (state_q == ST_FEED);
		cmd.emit_held = (state_q == ST_EMIT);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (round_step_q == STEP_LAST) begin
					state_d = ST_FEED;
				end
			end
			ST_FEED: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			round_step_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				round_step_q <= '0;
			end else if (cmd.round) begin
				round_step_q <= round_step_q + STEP_W'(1);
			end
		end
	end

endmodule

/* src/cc20_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_dpath
// Configuration, round registers, keystream block and output register.
// ----------------------------------------------------------------------------
module cc20_dpath import cc20_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  in_word_t               in_data,
	input  logic                   out_stall,
	output logic                   out_valid,
	output out_word_t              out_data,
	input  cc20_cmd_t              cmd,
	output cc20_sts_t              sts
);

	logic [63:0] key_part_q [4];
	logic [63:0] nonce_low_q;
	logic [31:0] nonce_high_q;
	logic [31:0] initial_counter_q;
	logic [31:0] block_count_q;
	logic [5:0]  byte_position_q;

	logic [31:0] round_words_q     [16];
	logic [31:0] keystream_words_q [16];
	logic [31:0] start_w           [16];
	logic [31:0] half_round_w      [16];

	in_word_t    held_q;
	out_word_t   out_q;
	logic        out_valid_q;

	in_word_t    src_w;
	logic [31:0] ks_word;
	logic [7:0]  ks_byte;
	logic        emit;

	// Block start words.
	always_comb begin
		start_w[0] = SIGMA0;
		start_w[1] = SIGMA1;
		start_w[2] = SIGMA2;
		start_w[3] = SIGMA3;
		for (int i = 0; i < 4; i++) begin
			start_w[4 + 2 * i] = key_part_q[i][31:0];
			start_w[5 + 2 * i] = key_part_q[i][63:32];
		end
		start_w[12] = block_count_q;
		start_w[13] = nonce_low_q[31:0];
		start_w[14] = nonce_low_q[63:32];
		start_w[15] = nonce_high_q;
	end

	// One half round: four independent quarter rounds on columns or diagonals.
	always_comb begin
		logic [1:0] q2;
		logic [3:0] ia, ib, ic, id;
		quad_t      qin, qout;
		for (int i = 0; i < 16; i++) begin
			half_round_w[i] = round_words_q[i];
		end
		for (int q = 0; q < 4; q++) begin
			q2 = 2'(q);
			ia = {2'b00, q2};
			ib = {2'b01, cmd.diagonal ? q2 + 2'd1 : q2};
			ic = {2'b10, cmd.diagonal ? q2 + 2'd2 : q2};
			id = {2'b11, cmd.diagonal ? q2 + 2'd3 : q2};
			qin.a = round_words_q[ia];
			qin.b = round_words_q[ib];
			qin.c = round_words_q[ic];
			qin.d = round_words_q[id];
			qout  = quarter_round(qin);
			half_round_w[ia] = qout.a;
			half_round_w[ib] = qout.b;
			half_round_w[ic] = qout.c;
			half_round_w[id] = qout.d;
		end
	end

	assign emit    = cmd.emit_in || cmd.emit_held;
	assign src_w   = cmd.emit_held ? held_q : in_data;
	assign ks_word = keystream_words_q[byte_position_q[5:2]];
	assign ks_byte = 8'(ks_word >> {byte_position_q[1:0], 3'b000});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				key_part_q[i] <= '0;
			end
			nonce_low_q       <= '0;
			nonce_high_q      <= '0;
			initial_counter_q <= '0;
			block_count_q     <= '0;
			byte_position_q   <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KEY_PART0:  key_part_q[0] <= cfg_data;
					REG_KEY_PART1:  key_part_q[1] <= cfg_data;
					REG_KEY_PART2:  key_part_q[2] <= cfg_data;
					REG_KEY_PART3:  key_part_q[3] <= cfg_data;
					REG_NONCE_LOW:  nonce_low_q   <= cfg_data;
					REG_NONCE_HIGH: nonce_high_q  <= cfg_data[31:0];
					REG_INITIAL_COUNTER: begin
						initial_counter_q <= cfg_data[31:0];
						block_count_q     <= cfg_data[31:0];
					end
					default: ;
				endcase
			end
			if (cmd.feed) begin
				block_count_q <= block_count_q + 32'd1;
			end
			if (emit) begin
				if (src_w.last_byte) begin
					byte_position_q <= '0;
					block_count_q   <= initial_counter_q;
				end else begin
					byte_position_q <= byte_position_q + 6'd1;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			held_q <= in_data;
			for (int i = 0; i < 16; i++) begin
				round_words_q[i] <= start_w[i];
			end
		end else if (cmd.round) begin
			for (int i = 0; i < 16; i++) begin
				round_words_q[i] <= half_round_w[i];
			end
		end
		if (cmd.feed) begin
			for (int i = 0; i < 16; i++) begin
				keystream_words_q[i] <= round_words_q[i] + start_w[i];
			end
		end
		if (emit) begin
			out_q.cipher_byte <= src_w.plaintext_byte ^ ks_byte;
			out_q.last_out    <= src_w.last_byte;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_q;
	assign sts.pos_zero = (byte_position_q == 6'd0);
	assign sts.out_busy = out_valid_q && out_stall;

endmodule

/* src/chacha20_stream_cipher_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_top
// ChaCha20 stream cipher (RFC 8439 state layout), one byte per word.
// ----------------------------------------------------------------------------
// Each input word carries one byte, which leaves XORed with the matching
// keystream byte. Inside a 64-byte block a byte is accepted every cycle while
// the output is not stalled, and its result is on the output in the next
// cycle. The first byte of every block (and of every message) starts a new
// keystream block, which is computed first by a single shared half-round
// unit (four quarter rounds in parallel) running one column or diagonal
// pass per cycle, followed by a feed-forward step and an
// output step. A word with last_byte set ends the message; the next byte
// restarts at block position zero with the counter reloaded from
// initial_counter. Configuration registers are written through cfg_we,
// cfg_index and cfg_data and should only be written while the block is idle.
// Writing initial_counter also reloads the running block counter.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_top import cc20_pkg::*; #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_word_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_word_t              out_data
);

	cc20_cmd_t cmd;
	cc20_sts_t sts;

	// Sequencer: handshake on the input side and round iteration count.
	cc20_ctrl #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: configuration, round state, keystream and output register.
	cc20_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	// A mid-block byte produces its result on the next cycle.
	a_mid_block_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_in |=> out_valid)
		else $error("mid-block byte did not produce a result");

	// A block start produces its result after the full round sequence.
	a_block_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> ##(2 * DOUBLE_ROUNDS + 3) out_valid)
		else $error("block start result missing after round sequence");

	// No input word is taken while a block is being generated.
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.round || cmd.feed || cmd.emit_held) |-> in_stall)
		else $error("input accepted during block generation");

endmodule

/* sim/chacha20_stream_cipher_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_top_tb
// Self-checking bench for the byte-serial ChaCha20 cipher.
// ----------------------------------------------------------------------------
// A short table of known-answer bytes comes first: the all-zero key block and
// the start of the well-known "Ladies and Gentlemen" vector, plus a write to
// the unused register index and a key change in the middle of a block. After
// that, phases of random messages follow under changing key, nonce and
// counter settings, with random idle cycles on both sides and one long
// receiver hold-off. Each word is checked against its known answer or an
// in-bench model of the keystream generator.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_top_tb;
	import cc20_pkg::*;

	localparam int DOUBLE_ROUNDS = 10;
	localparam int BLOCK_CYCLES  = 2 * DOUBLE_ROUNDS + 3;
	localparam int SETTLE_CYCLES = BLOCK_CYCLES + 8;
	localparam int RANDOM_ITEMS  = 1536;
	localparam int LONG_HOLD     = 300;
	localparam int MAX_CYCLES    = 1_000_000;

	// Index 7 decodes to no register and must be ignored.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [CFG_INDEX_W-1:0] ALL_REGS [7] = '{
		REG_KEY_PART0, REG_KEY_PART1, REG_KEY_PART2, REG_KEY_PART3,
		REG_NONCE_LOW, REG_NONCE_HIGH, REG_INITIAL_COUNTER
	};

	typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_e;

	typedef struct packed {
		row_kind_e              kind;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  value;
		logic [7:0]             text;
		logic                   last;
		logic                   known;
		logic [7:0]             known_cipher;
	} dir_row_t;

	localparam int NUM_DIR_ROWS = 27;
	localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
		// Zero key, zero nonce, counter 0: keystream opens with 76 b8.
		'{ROW_BYTE,  '0, '0, 8'h00, 1'b0, 1'b1, 8'h76},
		'{ROW_BYTE,  '0, '0, 8'hFF, 1'b1, 1'b1, 8'h47},
		'{ROW_BYTE,  '0, '0, 8'h00, 1'b1, 1'b1, 8'h76},
		'{ROW_WRITE, REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE,  '0, '0, 8'h0F, 1'b0, 1'b1, 8'h79},
		'{ROW_BYTE,  '0, '0, 8'hF0, 1'b1, 1'b1, 8'h48},
		// Key 00..1f, nonce 00 00 00 00 00 00 00 4a 00 00 00 00, counter 1.
		'{ROW_WRITE, REG_KEY_PART0, 64'h0706_0504_0302_0100, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_WRITE, REG_KEY_PART1, 64'h0F0E_0D0C_0B0A_0908, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_WRITE, REG_KEY_PART2, 64'h1716_1514_1312_1110, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_WRITE, REG_KEY_PART3, 64'h1F1E_1D1C_1B1A_1918, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_WRITE, REG_NONCE_LOW, 64'h4A00_0000_0000_0000, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_WRITE, REG_NONCE_HIGH, 64'h0, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_WRITE, REG_INITIAL_COUNTER, 64'h1, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE,  '0, '0, 8'h4C, 1'b0, 1'b1, 8'h6E},
		'{ROW_BYTE,  '0, '0, 8'h61, 1'b0, 1'b1, 8'h2E},
		'{ROW_BYTE,  '0, '0, 8'h64, 1'b0, 1'b1, 8'h35},
		'{ROW_BYTE,  '0, '0, 8'h69, 1'b0, 1'b1, 8'h9A},
		// A key change inside a block leaves the current keystream in place.
		'{ROW_WRITE, REG_KEY_PART0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE,  '0, '0, 8'h65, 1'b0, 1'b1, 8'h25},
		'{ROW_BYTE,  '0, '0, 8'h73, 1'b0, 1'b1, 8'h68},
		'{ROW_BYTE,  '0, '0, 8'h20, 1'b0, 1'b1, 8'hF9},
		'{ROW_BYTE,  '0, '0, 8'h61, 1'b1, 1'b1, 8'h80},
		// From here on the new key applies.
		'{ROW_BYTE,  '0, '0, 8'hFF, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE,  '0, '0, 8'h00, 1'b1, 1'b0, 8'h00},
		// Upper data bits of the 32-bit registers are dropped.
		'{ROW_WRITE, REG_NONCE_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_WRITE, REG_INITIAL_COUNTER, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE,  '0, '0, 8'h5A, 1'b1, 1'b0, 8'h00}
	};

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	in_word_t               in_data   = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	out_word_t              out_data;

	// Model state of the keystream generator.
	logic [63:0] key_reg [4];
	logic [63:0] nonce_lo_reg;
	logic [31:0] nonce_hi_reg;
	logic [31:0] first_counter;
	logic [31:0] block_counter;
	logic [5:0]  stream_pos;
	logic [31:0] keystream [16];

	out_word_t   pending_cipher [$];
	out_word_t   due_word;
	int unsigned failures     = 0;
	int unsigned cycle_count  = 0;
	int unsigned random_sent  = 0;
	bit          tx_calm      = 1'b0;
	bit          rx_calm      = 1'b0;
	bit          hold_off_req = 1'b0;

	chacha20_stream_cipher_top #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
		logic [63:0] twice;
		twice = {v, v} << n;
		return twice[63:32];
	endfunction

	function automatic void quarter_mix(inout logic [31:0] a, inout logic [31:0] b,
			inout logic [31:0] c, inout logic [31:0] d);
		a = a + b; d = rol32(d ^ a, 16);
		c = c + d; b = rol32(b ^ c, 12);
		a = a + b; d = rol32(d ^ a, 8);
		c = c + d; b = rol32(b ^ c, 7);
	endfunction

	// Builds the next 64-byte keystream block from the current settings.
	function automatic void refill_keystream();
		logic [31:0] init [16];
		logic [31:0] x [16];
		init[0] = SIGMA0;
		init[1] = SIGMA1;
		init[2] = SIGMA2;
		init[3] = SIGMA3;
		for (int i = 0; i < 4; i++) begin
			init[4 + 2 * i] = key_reg[i][31:0];
			init[5 + 2 * i] = key_reg[i][63:32];
		end
		init[12] = block_counter;
		init[13] = nonce_lo_reg[31:0];
		init[14] = nonce_lo_reg[63:32];
		init[15] = nonce_hi_reg;
		x = init;
		for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
			quarter_mix(x[0], x[4], x[8],  x[12]);
			quarter_mix(x[1], x[5], x[9],  x[13]);
			quarter_mix(x[2], x[6], x[10], x[14]);
			quarter_mix(x[3], x[7], x[11], x[15]);
			quarter_mix(x[0], x[5], x[10], x[15]);
			quarter_mix(x[1], x[6], x[11], x[12]);
			quarter_mix(x[2], x[7], x[8],  x[13]);
			quarter_mix(x[3], x[4], x[9],  x[14]);
		end
		for (int i = 0; i < 16; i++)
			keystream[i] = x[i] + init[i];
	endfunction

	function automatic out_word_t encrypt_byte(input logic [7:0] text, input logic last);
		out_word_t   res;
		logic [31:0] w;
		if (stream_pos == 6'd0) begin
			refill_keystream();
			block_counter = block_counter + 32'd1;
		end
		w = keystream[stream_pos[5:2]];
		res.cipher_byte = text ^ w[8 * stream_pos[1:0] +: 8];
		res.last_out    = last;
		if (last) begin
			stream_pos    = '0;
			block_counter = first_counter;
		end else begin
			stream_pos = stream_pos + 6'd1;
		end
		return res;
	endfunction

	function automatic void apply_write(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_KEY_PART0: key_reg[0] = val;
			REG_KEY_PART1: key_reg[1] = val;
			REG_KEY_PART2: key_reg[2] = val;
			REG_KEY_PART3: key_reg[3] = val;
			REG_NONCE_LOW: nonce_lo_reg = val;
			REG_NONCE_HIGH: nonce_hi_reg = val[31:0];
			REG_INITIAL_COUNTER: begin
				// The running counter follows at once, even mid-message.
				first_counter = val[31:0];
				block_counter = val[31:0];
			end
			default: ;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_value(input logic [CFG_INDEX_W-1:0] idx);
		int unsigned r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		// Counters just below the wrap point, so that long messages cross it.
		if (idx == REG_INITIAL_COUNTER && r < 4)
			return {$urandom, 32'hFFFF_FFFF - 32'($urandom_range(0, 2))};
		return {$urandom, $urandom};
	endfunction

	// Called at a falling edge; returns at a falling edge once the write is done.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		apply_write(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Drops valid, waits for every outstanding word, then lets any block
	// computation still in flight finish before the caller touches config.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_cipher.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Offers one byte after an optional idle gap and records its result once
	// the handshake completes. Returns at the falling edge after acceptance
	// with valid still high, so a following call continues back to back.
	task automatic send_byte(input logic [7:0] text, input logic last, input logic known,
			input logic [7:0] known_cipher);
		int        gap;
		int        pick;
		out_word_t next_word;
		pick = $urandom_range(0, 99);
		if (tx_calm || pick < 70)
			gap = 0;
		else if (pick < 95)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{plaintext_byte: text, last_byte: last};
		do @(posedge clk); while (in_stall);
		next_word = encrypt_byte(text, last);
		if (known)
			next_word.cipher_byte = known_cipher;
		pending_cipher.push_back(next_word);
		@(negedge clk);
	endtask

	// Receiver: random stalls, mostly short, now and then long, plus one long
	// hold-off on request so that the block backs up into its input.
	initial begin : receiver
		int stall_left;
		int pick;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				pick = $urandom_range(0, 99);
				if (rx_calm || pick < 65) begin
					out_stall <= 1'b0;
				end else begin
					out_stall <= 1'b1;
					stall_left = (pick < 96) ? $urandom_range(0, 2) : $urandom_range(10, 60);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_cipher.size() == 0) begin
				$error("unexpected word: cipher_byte %02h last_out %0b",
					out_data.cipher_byte, out_data.last_out);
				failures++;
			end else begin
				due_word = pending_cipher.pop_front();
				if (out_data.cipher_byte !== due_word.cipher_byte) begin
					$error("cipher_byte mismatch: expected %02h, actual %02h",
						due_word.cipher_byte, out_data.cipher_byte);
					failures++;
				end
				if (out_data.last_out !== due_word.last_out) begin
					$error("last_out mismatch: expected %0b, actual %0b",
						due_word.last_out, out_data.last_out);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= MAX_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int                     phase;
		int                     msgs;
		int                     len;
		int                     sel;
		bit                     open_tail;
		logic [CFG_INDEX_W-1:0] idx;

		for (int i = 0; i < 4; i++)
			key_reg[i] = '0;
		nonce_lo_reg  = '0;
		nonce_hi_reg  = '0;
		first_counter = '0;
		block_counter = '0;
		stream_pos    = '0;
		for (int i = 0; i < 16; i++)
			keystream[i] = '0;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].kind == ROW_WRITE) begin
				wait_idle();
				write_reg(DIR_ROWS[i].index, DIR_ROWS[i].value);
			end else begin
				send_byte(DIR_ROWS[i].text, DIR_ROWS[i].last, DIR_ROWS[i].known,
					DIR_ROWS[i].known_cipher);
			end
		end

		// Random phases. Phase 0 runs with everything zero, phase 1 with
		// everything at all ones (the counter wraps inside its first message),
		// and phase 2 carries the long receiver hold-off.
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			wait_idle();
			if (phase < 2) begin
				foreach (ALL_REGS[r])
					write_reg(ALL_REGS[r], (phase == 0) ? '0 : '1);
			end else begin
				foreach (ALL_REGS[r])
					if ($urandom_range(0, 1) == 1)
						write_reg(ALL_REGS[r], pick_value(ALL_REGS[r]));
				if ($urandom_range(0, 5) == 0)
					write_reg(REG_UNUSED, {$urandom, $urandom});
			end

			tx_calm = ($urandom_range(0, 4) == 0);
			rx_calm = ($urandom_range(0, 4) == 0);
			if (phase == 2) begin
				tx_calm      = 1'b1;
				rx_calm      = 1'b0;
				hold_off_req = 1'b1;
			end

			msgs = $urandom_range(2, 6);
			for (int m = 0; m < msgs && random_sent < RANDOM_ITEMS; m++) begin
				sel = $urandom_range(0, 9);
				if ((phase == 1 || phase == 2) && m == 0)
					len = 150;
				else if (sel < 6)
					len = $urandom_range(1, 16);
				else if (sel < 9)
					len = $urandom_range(17, 70);
				else
					len = $urandom_range(100, 200);
				// Now and then a message is left open and runs into the next.
				open_tail = ($urandom_range(0, 9) == 0);
				for (int b = 0; b < len && random_sent < RANDOM_ITEMS; b++) begin
					if (b > 0 && $urandom_range(0, 39) == 0) begin
						// Settings change between two bytes of one message.
						wait_idle();
						idx = ($urandom_range(0, 7) == 0) ? REG_UNUSED
							: ALL_REGS[$urandom_range(0, 6)];
						write_reg(idx, pick_value(idx));
					end
					send_byte(8'($urandom_range(0, 255)), (b == len - 1) && !open_tail,
						1'b0, 8'h00);
					random_sent++;
				end
			end
			phase++;
		end

		wait_idle();
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* chacha20_stream_cipher_top.f */
src/cc20_pkg.sv
src/cc20_ctrl.sv
src/cc20_dpath.sv
src/chacha20_stream_cipher_top.sv
sim/chacha20_stream_cipher_top_tb.sv
